// File: rtl/cidr_pkg.sv
`default_nettype none

package cidr_pkg;

  // item kinds
  localparam logic KIND_EXEC = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // opcode forms, bits 2:0
  localparam logic [2:0] FORM_PAIR = 3'd3;
  localparam logic [2:0] FORM_INC8 = 3'd4;
  localparam logic [2:0] FORM_DEC8 = 3'd5;

  // 8-bit targets, bits 5:3
  localparam logic [2:0] TGT_B   = 3'd0;
  localparam logic [2:0] TGT_C   = 3'd1;
  localparam logic [2:0] TGT_D   = 3'd2;
  localparam logic [2:0] TGT_E   = 3'd3;
  localparam logic [2:0] TGT_H   = 3'd4;
  localparam logic [2:0] TGT_L   = 3'd5;
  localparam logic [2:0] TGT_MEM = 3'd6;
  localparam logic [2:0] TGT_A   = 3'd7;

  // pair codes, bits 5:4
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  // load selects
  localparam logic [2:0] LSEL_AF = 3'd0;
  localparam logic [2:0] LSEL_BC = 3'd1;
  localparam logic [2:0] LSEL_DE = 3'd2;
  localparam logic [2:0] LSEL_HL = 3'd3;
  localparam logic [2:0] LSEL_SP = 3'd4;

  // cycle counts
  localparam logic [3:0] CYC_NONE = 4'd0;
  localparam logic [3:0] CYC_R8   = 4'd4;
  localparam logic [3:0] CYC_PAIR = 4'd8;
  localparam logic [3:0] CYC_MEM  = 4'd12;

  // flag nibble positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [7:0]  a;
    logic [3:0]  flags;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
  } regs_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  opcode;
    logic [7:0]  mem_read_data;
    logic [2:0]  load_select;
    logic [15:0] load_value;
  } item_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_write_data;
    logic [3:0]  cycles;
    logic        opcode_ok;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/cidr_exec.sv
`default_nettype none

module cidr_exec (
  input  wire cidr_pkg::regs_t   cur,
  input  wire cidr_pkg::item_t   item,
  output cidr_pkg::regs_t        nxt,
  output cidr_pkg::result_t      res
);

  logic [2:0]  form;
  logic [2:0]  tgt;
  logic [1:0]  psel;
  logic        dec;
  logic [15:0] pval;
  logic [15:0] pres;
  logic [7:0]  opnd;
  logic [7:0]  r8;
  logic [3:0]  fl8;

  assign form = item.opcode[2:0];
  assign tgt  = item.opcode[5:3];
  assign psel = tgt[2:1];
  assign dec  = (form == cidr_pkg::FORM_DEC8);

  // pair operand and +/-1
  always_comb begin
    case (psel)
      cidr_pkg::PAIR_BC: pval = cur.bc;
      cidr_pkg::PAIR_DE: pval = cur.de;
      cidr_pkg::PAIR_HL: pval = cur.hl;
      default:           pval = cur.sp;
    endcase
    pres = tgt[0] ? (pval - 16'd1) : (pval + 16'd1);
  end

  // byte operand and flags
  always_comb begin
    case (tgt)
      cidr_pkg::TGT_B:   opnd = cur.bc[15:8];
      cidr_pkg::TGT_C:   opnd = cur.bc[7:0];
      cidr_pkg::TGT_D:   opnd = cur.de[15:8];
      cidr_pkg::TGT_E:   opnd = cur.de[7:0];
      cidr_pkg::TGT_H:   opnd = cur.hl[15:8];
      cidr_pkg::TGT_L:   opnd = cur.hl[7:0];
      cidr_pkg::TGT_MEM: opnd = item.mem_read_data;
      default:           opnd = cur.a;
    endcase
    r8 = dec ? (opnd - 8'd1) : (opnd + 8'd1);
    fl8 = '0;
    fl8[cidr_pkg::FLAG_Z] = (r8 == 8'h00);
    fl8[cidr_pkg::FLAG_N] = dec;
    fl8[cidr_pkg::FLAG_H] = dec ? (r8[3:0] == 4'hf) : (r8[3:0] == 4'h0);
    fl8[cidr_pkg::FLAG_C] = cur.flags[cidr_pkg::FLAG_C];
  end

  always_comb begin
    nxt = cur;
    res = '0;
    if (item.kind == cidr_pkg::KIND_LOAD) begin
      case (item.load_select)
        cidr_pkg::LSEL_AF: begin
          nxt.a     = item.load_value[15:8];
          nxt.flags = item.load_value[7:4];
        end
        cidr_pkg::LSEL_BC: nxt.bc = item.load_value;
        cidr_pkg::LSEL_DE: nxt.de = item.load_value;
        cidr_pkg::LSEL_HL: nxt.hl = item.load_value;
        cidr_pkg::LSEL_SP: nxt.sp = item.load_value;
        default: ;
      endcase
    end else if (item.opcode[7:6] == 2'b00) begin
      if (form == cidr_pkg::FORM_PAIR) begin
        case (psel)
          cidr_pkg::PAIR_BC: nxt.bc = pres;
          cidr_pkg::PAIR_DE: nxt.de = pres;
          cidr_pkg::PAIR_HL: nxt.hl = pres;
          default:           nxt.sp = pres;
        endcase
        res.cycles    = cidr_pkg::CYC_PAIR;
        res.opcode_ok = 1'b1;
      end else if (form == cidr_pkg::FORM_INC8 || form == cidr_pkg::FORM_DEC8) begin
        nxt.flags     = fl8;
        res.opcode_ok = 1'b1;
        res.cycles    = cidr_pkg::CYC_R8;
        case (tgt)
          cidr_pkg::TGT_B: nxt.bc[15:8] = r8;
          cidr_pkg::TGT_C: nxt.bc[7:0]  = r8;
          cidr_pkg::TGT_D: nxt.de[15:8] = r8;
          cidr_pkg::TGT_E: nxt.de[7:0]  = r8;
          cidr_pkg::TGT_H: nxt.hl[15:8] = r8;
          cidr_pkg::TGT_L: nxt.hl[7:0]  = r8;
          cidr_pkg::TGT_MEM: begin
            res.mem_write      = 1'b1;
            res.mem_addr       = cur.hl;
            res.mem_write_data = r8;
            res.cycles         = cidr_pkg::CYC_MEM;
          end
          default: nxt.a = r8;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/cpu_inc_dec_register_unit.sv
// INC/DEC execution unit with its own register file (A, F, BC, DE, HL, SP).
// Each request either runs one opcode (8-bit INC/DEC on B..L, A or the byte
// at (HL), or 16-bit pair INC/DEC) or loads one register word. Requests are
// taken at one per clock while in_stall is low: a request is captured in an input register, runs
// through one pass of increment/decrement and flag logic, and its result
// moves into the output register when that register is free or draining.
// The register values shown on out_a..out_sp are those after the request
// now on the output. The input register and output register let a new
// request enter while a finished one waits on out_stall; in_stall rises only
// when both are full and the output is stalled. Opcodes that are not
// INC/DEC come back with out_opcode_ok low, out_cycles zero and no change.
// A (HL) form does not touch memory itself: it reports the write on
// out_mem_write, out_mem_addr (HL) and out_mem_write_data.
`default_nettype none

module cpu_inc_dec_register_unit (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_kind,
  input  wire  [7:0]  in_opcode,
  input  wire  [7:0]  in_mem_read_data,
  input  wire  [2:0]  in_load_select,
  input  wire  [15:0] in_load_value,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_a,
  output logic [7:0]  out_flags,
  output logic [15:0] out_bc,
  output logic [15:0] out_de,
  output logic [15:0] out_hl,
  output logic [15:0] out_sp,
  output logic        out_mem_write,
  output logic [15:0] out_mem_addr,
  output logic [7:0]  out_mem_write_data,
  output logic [3:0]  out_cycles,
  output logic        out_opcode_ok
);

  // input register
  logic              in_valid_r;
  cidr_pkg::item_t   item_r;
  // output register
  logic              out_valid_r;
  cidr_pkg::result_t res_r;
  // architectural registers
  cidr_pkg::regs_t   regs_r;

  cidr_pkg::regs_t   regs_nxt;
  cidr_pkg::result_t res_nxt;
  logic              advance;
  logic              take;

  // execute when the output register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  cidr_exec u_exec (
    .cur  (regs_r),
    .item (item_r),
    .nxt  (regs_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      regs_r      <= '0;
    end else begin
      if (take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        regs_r      <= regs_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{kind: in_kind, opcode: in_opcode, mem_read_data: in_mem_read_data,
                  load_select: in_load_select, load_value: in_load_value};
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // register file always matches the request on the output
  assign out_valid          = out_valid_r;
  assign out_a              = regs_r.a;
  assign out_flags          = {regs_r.flags, 4'b0000};
  assign out_bc             = regs_r.bc;
  assign out_de             = regs_r.de;
  assign out_hl             = regs_r.hl;
  assign out_sp             = regs_r.sp;
  assign out_mem_write      = res_r.mem_write;
  assign out_mem_addr       = res_r.mem_addr;
  assign out_mem_write_data = res_r.mem_write_data;
  assign out_cycles         = res_r.cycles;
  assign out_opcode_ok      = res_r.opcode_ok;

endmodule

`default_nettype wire

// File: rtl/cidr_checker.sv
`default_nettype none

module cidr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [7:0]  out_a,
  input wire [15:0] out_hl,
  input wire        out_mem_write,
  input wire [15:0] out_mem_addr,
  input wire [7:0]  out_mem_write_data,
  input wire [3:0]  out_cycles,
  input wire        out_opcode_ok
);

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cycles) &&
      $stable(out_mem_write_data) && $stable(out_a) && $stable(out_hl))
    else $error("stalled result changed");

  // memory forms report CYC_MEM in out_cycles and count as executed
  a_mem_cyc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_write |-> out_opcode_ok && out_cycles == cidr_pkg::CYC_MEM)
    else $error("memory write with wrong cycle count");

  // memory write goes to HL, which the memory form leaves alone
  a_mem_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_write |-> out_mem_addr == out_hl)
    else $error("memory address differs from HL");

  // rejected opcodes and loads report nothing
  a_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_opcode_ok |->
      out_cycles == cidr_pkg::CYC_NONE && !out_mem_write)
    else $error("non-executed request reports work");

endmodule

bind cpu_inc_dec_register_unit cidr_checker u_cidr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_a              (out_a),
  .out_hl             (out_hl),
  .out_mem_write      (out_mem_write),
  .out_mem_addr       (out_mem_addr),
  .out_mem_write_data (out_mem_write_data),
  .out_cycles         (out_cycles),
  .out_opcode_ok      (out_opcode_ok)
);

`default_nettype wire
